>>> src/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int ID_BITS       = 16;
    localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int ERR_BITS      = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [ERR_BITS-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [ID_BITS-1:0]       id;
    } t_entry;

    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } t_cell_ctl;

endpackage

>>> src/spq_cell.sv
// One slot of the sorted shift-register chain.
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  logic      i_left_after,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_after
);

    t_entry r_entry;
    t_entry n_entry;

    // The chain is sorted, so this flag is true for a prefix of the cells only.
    assign o_after = i_occupied && (r_entry.prio <= i_new.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_insert) begin
            if (o_after) begin
                n_entry = r_entry;
            end else if (i_left_after) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.do_remove) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> src/stable_priority_queue_core.sv
// Top level of the stable priority queue: a chain of slot cells and the result register.
// The queue holds up to 16 entries, kept sorted in a row of cells with the head in
// cell 0; lower priority values leave first, and equal priorities leave in arrival
// order. All cells compare against the new entry at once and shift left or right in the
// same clock, so one item is accepted per cycle for as long as the result register is
// drained. Each item gives exactly one result, which carries the removed entry, the
// occupancy after the item and an error code (insert into a full queue is dropped,
// remove from an empty queue returns nothing).
module stable_priority_queue_core
    import spq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_opcode,
    input  logic [PRIORITY_BITS-1:0] i_priority_req,
    input  logic [ID_BITS-1:0]       i_item_id,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_popped_valid,
    output logic [PRIORITY_BITS-1:0] o_popped_priority,
    output logic [ID_BITS-1:0]       o_popped_id,
    output logic [COUNT_BITS-1:0]    o_occupancy,
    output logic                     o_is_empty,
    output logic [ERR_BITS-1:0]      o_error_code
);

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_out_valid;
    logic                  r_popped_valid;
    t_entry                r_popped;
    t_err                  r_err;
    t_err                  n_err;

    logic      accept;
    logic      full;
    logic      empty;
    t_cell_ctl ctl;
    t_entry    new_entry;

    t_entry cell_entry [QUEUE_DEPTH];
    logic   cell_after [QUEUE_DEPTH];

    assign full      = (r_count == COUNT_BITS'(QUEUE_DEPTH));
    assign empty     = (r_count == '0);
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept    = i_in_valid && !o_in_stall;
    assign new_entry = '{prio: i_priority_req, id: i_item_id};

    assign ctl.do_insert = accept && (i_opcode == OP_INSERT) && !full;
    assign ctl.do_remove = accept && (i_opcode == OP_REMOVE) && !empty;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry left;
        logic   left_after;
        t_entry right;
        logic   occupied;

        assign occupied = (COUNT_BITS'(g) < r_count);

        if (g == 0) begin : g_head
            assign left       = new_entry;
            assign left_after = 1'b1;
        end else begin : g_body
            assign left       = cell_entry[g-1];
            assign left_after = cell_after[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right = cell_entry[g];
        end else begin : g_mid
            assign right = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (occupied),
            .i_new        (new_entry),
            .i_left       (left),
            .i_left_after (left_after),
            .i_right      (right),
            .o_entry      (cell_entry[g]),
            .o_after      (cell_after[g])
        );
    end

    always_comb begin
        n_count = r_count;
        n_err   = ERR_OK;
        if (i_opcode == OP_INSERT) begin
            if (full) begin
                n_err = ERR_FULL;
            end else begin
                n_count = r_count + COUNT_BITS'(1);
            end
        end else begin
            if (empty) begin
                n_err = ERR_EMPTY;
            end else begin
                n_count = r_count - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the popped fields read zero unless a remove took an entry.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped_valid <= ctl.do_remove;
            r_popped       <= ctl.do_remove ? cell_entry[0] : '0;
            r_err          <= n_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_popped_valid    = r_popped_valid;
    assign o_popped_priority = r_popped.prio;
    assign o_popped_id       = r_popped.id;
    assign o_occupancy       = r_count;
    assign o_is_empty        = empty;
    assign o_error_code      = r_err;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stable priority queue core.
module testbench
    import spq_pkg::*;
();

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic                     popped_valid;
        logic [PRIORITY_BITS-1:0] popped_priority;
        logic [ID_BITS-1:0]       popped_id;
        logic [COUNT_BITS-1:0]    occupancy;
        logic                     is_empty;
        t_err                     error_code;
    } t_outcome;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     opcode = OP_INSERT;
    logic [PRIORITY_BITS-1:0] priority_req = '0;
    logic [ID_BITS-1:0]       item_id = '0;
    logic                     out_stall = 1'b0;

    logic                     in_stall;
    logic                     out_valid;
    logic                     popped_valid;
    logic [PRIORITY_BITS-1:0] popped_priority;
    logic [ID_BITS-1:0]       popped_id;
    logic [COUNT_BITS-1:0]    occupancy;
    logic                     is_empty;
    logic [ERR_BITS-1:0]      error_code;

    // Shadow of the sorted slot row, head at index 0.
    t_entry   shadow_slots[$];
    t_outcome pending_outcomes[$];

    int error_count = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_pct = 0;
    int stall_phase_left = 0;
    int insert_count = 0;
    int remove_count = 0;
    int full_drop_count = 0;
    int empty_remove_count = 0;
    int results_checked = 0;

    stable_priority_queue_core u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_opcode          (opcode),
        .i_priority_req    (priority_req),
        .i_item_id         (item_id),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_popped_valid    (popped_valid),
        .o_popped_priority (popped_priority),
        .o_popped_id       (popped_id),
        .o_occupancy       (occupancy),
        .o_is_empty        (is_empty),
        .o_error_code      (error_code)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Applies one accepted item to the shadow queue and records the outcome it implies.
    function automatic void apply_to_shadow(input logic op, input logic [PRIORITY_BITS-1:0] prio,
                                            input logic [ID_BITS-1:0] id);
        t_outcome o;
        t_entry   e;
        int       pos;
        o.popped_valid    = 1'b0;
        o.popped_priority = '0;
        o.popped_id       = '0;
        o.error_code      = ERR_OK;
        if (op == OP_INSERT) begin
            insert_count++;
            if (shadow_slots.size() >= QUEUE_DEPTH) begin
                o.error_code = ERR_FULL;
                full_drop_count++;
            end else begin
                // The new entry goes behind every entry of equal or lower value.
                pos = 0;
                while (pos < shadow_slots.size() && shadow_slots[pos].prio <= prio) pos++;
                e.prio = prio;
                e.id   = id;
                shadow_slots.insert(pos, e);
            end
        end else begin
            remove_count++;
            if (shadow_slots.size() == 0) begin
                o.error_code = ERR_EMPTY;
                empty_remove_count++;
            end else begin
                e = shadow_slots.pop_front();
                o.popped_valid    = 1'b1;
                o.popped_priority = e.prio;
                o.popped_id       = e.id;
            end
        end
        o.occupancy = COUNT_BITS'(shadow_slots.size());
        o.is_empty  = (shadow_slots.size() == 0);
        pending_outcomes.push_back(o);
    endfunction

    // Small values and the two extremes are favored so that equal priorities show up often.
    function automatic logic [PRIORITY_BITS-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return PRIORITY_BITS'($urandom_range(0, 3));
            1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return PRIORITY_BITS'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        error_count++;
    endtask

    // Offers one item and returns at the edge where it is taken.
    task automatic send_item(input logic op, input logic [PRIORITY_BITS-1:0] prio,
                             input logic [ID_BITS-1:0] id);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        opcode       <= op;
        priority_req <= prio;
        item_id      <= id;
        do @(posedge clk); while (in_stall);
        apply_to_shadow(op, prio, id);
    endtask

    task automatic send_random_insert();
        send_item(OP_INSERT, pick_priority(), ID_BITS'($urandom));
    endtask

    task automatic send_random_remove();
        send_item(OP_REMOVE, PRIORITY_BITS'($urandom), ID_BITS'($urandom));
    endtask

    task automatic test_remove_empty();
        send_item(OP_REMOVE, '1, '1);
    endtask

    // Fills the queue with extreme and repeated priorities.
    task automatic test_fill_to_full();
        logic [PRIORITY_BITS-1:0] prio;
        logic [ID_BITS-1:0]       id;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            prio = (i % 3 == 0) ? PRIORITY_BITS'(128) : ((i % 3 == 1) ? '1 : '0);
            id   = (i % 2 != 0) ? ('1 ^ ID_BITS'(i)) : ID_BITS'(i);
            send_item(OP_INSERT, prio, id);
        end
    endtask

    task automatic test_insert_when_full();
        send_item(OP_INSERT, '0, ID_BITS'(16'hABCD));
    endtask

    task automatic test_stable_order();
        repeat (4) send_random_remove();
    endtask

    // Phases of random length, each with its own mix of inserts and removes.
    task automatic test_random_mix(input int n_items);
        int insert_pct;
        int phase_left;
        phase_left = 0;
        insert_pct = 50;
        repeat (n_items) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: insert_pct = 25;
                    1: insert_pct = 50;
                    default: insert_pct = 75;
                endcase
            end
            phase_left--;
            if ($urandom_range(0, 99) < insert_pct) send_random_insert();
            else send_random_remove();
        end
    endtask

    // Rounds that fill past full and drain past empty, with a little noise on the way.
    task automatic test_fill_and_drain(input int n_rounds);
        repeat (n_rounds) begin
            while (shadow_slots.size() < QUEUE_DEPTH) begin
                if ($urandom_range(0, 99) < 85) send_random_insert();
                else send_random_remove();
            end
            repeat ($urandom_range(1, 3)) send_random_insert();
            while (shadow_slots.size() > 0) begin
                if ($urandom_range(0, 99) < 85) send_random_remove();
                else send_random_insert();
            end
            repeat ($urandom_range(1, 3)) send_random_remove();
        end
    endtask

    // The receiver changes its stall rate in phases of random length, including stall-free stretches.
    always @(posedge clk) begin
        if (stall_phase_left == 0) begin
            stall_phase_left = $urandom_range(16, 64);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 75;
            endcase
        end
        stall_phase_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        t_outcome want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $display("MISMATCH at %0t: result with no item outstanding", $realtime);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (popped_valid !== want.popped_valid)
                    report_mismatch("popped_valid", 32'(popped_valid),
                                    32'(want.popped_valid));
                if (popped_priority !== want.popped_priority)
                    report_mismatch("popped_priority", 32'(popped_priority),
                                    32'(want.popped_priority));
                if (popped_id !== want.popped_id)
                    report_mismatch("popped_id", 32'(popped_id), 32'(want.popped_id));
                if (occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(occupancy), 32'(want.occupancy));
                if (is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(is_empty), 32'(want.is_empty));
                if (error_code !== want.error_code)
                    report_mismatch("error_code", 32'(error_code), 32'(want.error_code));
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_remove_empty();
        test_fill_to_full();
        test_insert_when_full();
        test_stable_order();
        test_random_mix(400);
        test_fill_and_drain(8);

        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d inserts (%0d dropped as full) and %0d removes (%0d on empty).",
                 insert_count, full_drop_count, remove_count, empty_remove_count);
        $display("Checked %0d results against the shadow queue.", results_checked);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue_core.sv
dv/testbench.sv
